@@ hdl/kmp_stream_matcher_defines.svh @@
// Assertion macros shared by the checker files of the string matcher.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef KMP_STREAM_MATCHER_DEFINES_SVH
`define KMP_STREAM_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define KMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define KMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/kms_pkg.sv @@
// Types and constants of the streaming KMP string matcher.
// No dependencies; used by the interfaces, the engine and the top level.
package kms_pkg;

    localparam int KIND_W  = 2;
    localparam int SYM_W   = 8;
    localparam int TOTAL_W = 24;
    localparam int SIZE_W  = 7;

    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [SYM_W-1:0]   sym_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [SIZE_W-1:0]  size_t;

    // item kinds
    localparam kind_t KIND_APPEND  = 2'd0;
    localparam kind_t KIND_TEXT    = 2'd1;
    localparam kind_t KIND_CLEAR   = 2'd2;
    localparam kind_t KIND_RESTART = 2'd3;

    localparam total_t TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic   match_found;
        total_t match_total;
        size_t  matched_prefix;
        size_t  pattern_size;
        logic   overflow;
    } kms_result_t;

endpackage

@@ hdl/kms_stream_if.sv @@
// Valid/ready channel interfaces for the matcher's item and result beats.
// Depends on kms_pkg.
interface kms_item_if;
    import kms_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    sym_t  symbol;

    modport source (output valid, kind, symbol, input ready);
    modport sink   (input valid, kind, symbol, output ready);
endinterface

interface kms_result_if;
    import kms_pkg::*;

    logic   valid;
    logic   ready;
    logic   match_found;
    total_t match_total;
    size_t  matched_prefix;
    size_t  pattern_size;
    logic   overflow;

    modport source (output valid, match_found, match_total, matched_prefix,
                    pattern_size, overflow, input ready);
    modport sink   (input valid, match_found, match_total, matched_prefix,
                    pattern_size, overflow, output ready);
endinterface

@@ hdl/kms_engine.sv @@
// Sequencer of the KMP matcher: pattern and failure memories, border build
// and text scan. Depends on kms_pkg.
module kms_engine #(
    parameter int MAX_PATTERN = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  kms_pkg::kind_t       kind,
    input  kms_pkg::sym_t        symbol,
    input  logic                 res_ready,
    output logic                 idle,
    output logic                 res_valid,
    output kms_pkg::kms_result_t res
);
    import kms_pkg::*;

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW = $clog2(MAX_PATTERN + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_STEP = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] build_reg, build_next;
    logic [IW-1:0] match_reg, match_next;
    total_t        occ_reg, occ_next;
    logic          found_reg, found_next;
    logic          drop_reg, drop_next;
    kind_t         kind_reg;
    sym_t          sym_reg;

    sym_t          pat_mem [MAX_PATTERN];
    logic [IW-1:0] fail_mem [MAX_PATTERN];
    sym_t          pat_q;
    logic [IW-1:0] fail_q;

    logic [IW-1:0] rd_k;
    logic [IW-1:0] pos;
    logic          pat_we, fail_we;
    logic [IW-1:0] fail_wdata;
    logic          fin;
    logic          hit;
    logic [CW-1:0] knew;

    assign pos  = count_reg[IW-1:0];
    assign hit  = (pat_q == sym_reg);
    assign knew = CW'(k_reg) + CW'(hit);
    assign idle = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        count_next = count_reg;
        build_next = build_reg;
        match_next = match_reg;
        occ_next   = occ_reg;
        found_next = found_reg;
        drop_next  = drop_reg;
        rd_k       = match_reg;
        pat_we     = 1'b0;
        fail_we    = 1'b0;
        fail_wdata = '0;
        fin        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    found_next = 1'b0;
                    drop_next  = 1'b0;
                    case (kind)
                        KIND_APPEND:
                        begin
                            if (count_reg == CW'(MAX_PATTERN))
                            begin
                                drop_next = 1'b1;
                                fin       = 1'b1;
                            end
                            else
                            begin
                                pat_we = 1'b1;
                                if (count_reg == '0)
                                begin
                                    fail_we    = 1'b1;
                                    build_next = '0;
                                    count_next = count_reg + CW'(1);
                                    fin        = 1'b1;
                                end
                                else
                                begin
                                    rd_k       = build_reg;
                                    k_next     = build_reg;
                                    state_next = ST_STEP;
                                end
                            end
                        end
                        KIND_TEXT:
                        begin
                            if (count_reg == '0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                rd_k       = match_reg;
                                k_next     = match_reg;
                                state_next = ST_STEP;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            build_next = '0;
                            match_next = '0;
                            occ_next   = '0;
                            fin        = 1'b1;
                        end
                        default:
                        begin
                            match_next = '0;
                            occ_next   = '0;
                            fin        = 1'b1;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                if ((k_reg != '0) && !hit)
                begin
                    // follow one failure link
                    k_next = fail_q;
                    rd_k   = fail_q;
                end
                else
                begin
                    fin = 1'b1;
                    if (kind_reg == KIND_APPEND)
                    begin
                        build_next = knew[IW-1:0];
                        fail_we    = 1'b1;
                        fail_wdata = knew[IW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                    else if (knew == count_reg)
                    begin
                        // full occurrence: fall back to border of last byte
                        found_next = 1'b1;
                        if (occ_reg != TOTAL_MAX)
                        begin
                            occ_next = occ_reg + TOTAL_W'(1);
                        end
                        match_next = build_reg;
                    end
                    else
                    begin
                        match_next = knew[IW-1:0];
                    end
                end
            end
            ST_WAIT:
            begin
                state_next = ST_WAIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_valid = fin || (state_reg == ST_WAIT);
        if (res_valid)
        begin
            state_next = res_ready ? ST_IDLE : ST_WAIT;
        end
    end

    // result from next-state values; equals held state while waiting
    always_comb
    begin
        res.match_found    = found_next;
        res.match_total    = occ_next;
        res.matched_prefix = SIZE_W'(match_next);
        res.pattern_size   = SIZE_W'(count_next);
        res.overflow       = drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            build_reg <= '0;
            match_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            build_reg <= build_next;
            match_reg <= match_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        found_reg <= found_next;
        drop_reg  <= drop_next;
        if (start && idle)
        begin
            kind_reg <= kind;
            sym_reg  <= symbol;
        end
    end

    // pattern and failure memories, registered reads
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pos] <= symbol;
        end
        if (fail_we)
        begin
            fail_mem[pos] <= fail_wdata;
        end
        pat_q  <= pat_mem[rd_k];
        fail_q <= fail_mem[rd_k - IW'(1)];
    end

endmodule

@@ hdl/kmp_stream_matcher.sv @@
// Streaming Knuth-Morris-Pratt matcher, top level.
//
// Channels: "item" takes one beat per command (kind, symbol); "result"
// returns exactly one beat per item, in order. Kinds: append a pattern
// byte, scan a text byte, clear pattern and matcher, restart text only.
//
// Clear, restart, a dropped append, the first pattern byte and a text byte
// against an empty pattern finish in the cycle they are accepted. Other
// appends and text bytes go to a step state that compares the pattern byte
// at the current border and follows one failure link per mismatch, each a
// registered read of the pattern and failure memories plus a compare. The
// result is registered in the output register before it is offered.
//
// Reset clears the pattern length, border, matched prefix and count; the
// memories keep stale data that is never read. A stalled result waits in
// the output register while the next item is accepted and worked on; that
// item then holds its result and takes no further beat until the output
// register frees.
//
// Depends on kms_pkg, kms_stream_if and kms_engine.
module kmp_stream_matcher #(
    parameter int MAX_PATTERN = 64
) (
    input logic          clk,
    input logic          rst_n,
    kms_item_if.sink     item,
    kms_result_if.source result
);
    import kms_pkg::*;

    logic        eng_idle;
    logic        eng_start;
    logic        res_valid;
    logic        res_ready;
    kms_result_t res;

    logic        out_valid_reg;
    kms_result_t out_data_reg;

    assign item.ready = eng_idle;
    assign eng_start  = item.valid && eng_idle;

    // output register frees when empty or being drained this cycle
    assign res_ready = !out_valid_reg || result.ready;

    kms_engine #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (eng_start),
        .kind      (item.kind),
        .symbol    (item.symbol),
        .res_ready (res_ready),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.match_found    = out_data_reg.match_found;
    assign result.match_total    = out_data_reg.match_total;
    assign result.matched_prefix = out_data_reg.matched_prefix;
    assign result.pattern_size   = out_data_reg.pattern_size;
    assign result.overflow       = out_data_reg.overflow;

endmodule

@@ hdl/kms_checker.sv @@
// Port-level checks of the KMP matcher, bound to its top level.
// Depends on kms_pkg and kmp_stream_matcher_defines.svh.
`include "kmp_stream_matcher_defines.svh"

module kms_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_ready,
    input logic            res_valid,
    input logic            res_ready,
    input logic            match_found,
    input kms_pkg::total_t match_total,
    input kms_pkg::size_t  matched_prefix
);
    import kms_pkg::*;

    logic       in_fire;
    logic       out_fire;
    logic [1:0] pending_reg;

    assign in_fire  = item_valid && item_ready;
    assign out_fire = res_valid && res_ready;

    // beats accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_fire && !out_fire)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (out_fire && !in_fire)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    `KMS_ASSERT_NOW(a_no_phantom, out_fire, pending_reg != 2'd0, "result beat without an item")
    `KMS_ASSERT_NOW(a_depth, 1'b1, pending_reg != 2'd3, "more than two items in flight")
    `KMS_ASSERT_NOW(a_found_counted, res_valid && match_found, match_total != '0, "match not counted")
    `KMS_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid && $stable(match_total) && $stable(matched_prefix), "stalled result changed")

endmodule

bind kmp_stream_matcher kms_checker u_kms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .match_found    (result.match_found),
    .match_total    (result.match_total),
    .matched_prefix (result.matched_prefix)
);

@@ test/tb_top.sv @@
// Self-checking bench for kmp_stream_matcher: pattern loads, text scans, clears and restarts.
// Depends on kms_pkg, kms_stream_if and the matcher RTL; holds its own KMP predictor.
`timescale 1ns / 1ps

module tb_top;
    import kms_pkg::*;

    localparam int PAT_DEPTH   = 64;    // matches the MAX_PATTERN the dut is built with
    localparam int RANDOM_CMDS = 1600;
    localparam int QUIET_LIMIT = 2000;  // cycles with no beat on either channel
    localparam int DRAIN_WAIT  = 150;   // longest fallback chain plus output slack

    typedef struct {
        kind_t kind;
        sym_t  symbol;
    } scan_cmd_t;

    logic clk;
    logic rst_n;

    kms_item_if   item_ch ();
    kms_result_if result_ch ();

    kmp_stream_matcher #(
        .MAX_PATTERN(PAT_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor: own copy of the pattern, its border table and the scan
    // state. One call per accepted command beat.
    // ------------------------------------------------------------------
    sym_t       pat_bytes  [PAT_DEPTH];
    logic [5:0] border_len [PAT_DEPTH];
    size_t      pat_len;
    size_t      build_border;
    size_t      cur_prefix;
    total_t     hit_count;

    // walk failure links until the next pattern byte equals c or the prefix is empty, then extend on a match
    function automatic size_t follow_links(size_t k, sym_t c);
        while (k != '0 && pat_bytes[k[5:0]] != c)
            k = {1'b0, border_len[k[5:0] - 6'd1]};
        if (pat_bytes[k[5:0]] == c)
            k = k + size_t'(1);
        return k;
    endfunction

    function automatic kms_result_t kmp_step(kind_t kind, sym_t c);
        kms_result_t r;
        size_t       k;
        r = '0;
        case (kind)
            KIND_APPEND:
            begin
                if (pat_len >= PAT_DEPTH)
                    r.overflow = 1'b1;   // store full: byte dropped, nothing moves
                else
                begin
                    pat_bytes[pat_len[5:0]] = c;
                    build_border = (pat_len == 0) ? size_t'(0) : follow_links(build_border, c);
                    border_len[pat_len[5:0]] = build_border[5:0];
                    pat_len = pat_len + size_t'(1);
                end
            end
            KIND_TEXT:
            begin
                // empty pattern never matches and the prefix stays at zero
                if (pat_len > 0)
                begin
                    k = follow_links(cur_prefix, c);
                    if (k == pat_len)
                    begin
                        r.match_found = 1'b1;
                        if (hit_count != TOTAL_MAX)
                            hit_count = hit_count + total_t'(1);
                        // fall back so overlapping occurrences are still seen
                        k = {1'b0, border_len[pat_len[5:0] - 6'd1]};
                    end
                    cur_prefix = k;
                end
            end
            KIND_CLEAR:
            begin
                pat_len      = '0;
                build_border = '0;
                cur_prefix   = '0;
                hit_count    = '0;
            end
            default:
            begin
                cur_prefix = '0;
                hit_count  = '0;
            end
        endcase
        r.match_total    = hit_count;
        r.matched_prefix = cur_prefix;
        r.pattern_size   = pat_len;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus store, filled once at time zero
    // ------------------------------------------------------------------
    scan_cmd_t   command_queue[$];
    kms_result_t predicted_reports[$];

    function automatic sym_t rand_sym();
        return sym_t'($urandom_range(0, 255));
    endfunction

    // small alphabet around a random base keeps matches frequent
    function automatic sym_t alpha_sym(sym_t base, int alpha);
        return base + sym_t'($urandom_range(0, alpha - 1));
    endfunction

    task automatic push_cmd(kind_t kind, sym_t symbol);
        scan_cmd_t cmd;
        cmd.kind   = kind;
        cmd.symbol = symbol;
        command_queue.push_back(cmd);
    endtask

    task automatic directed_cmds();
        push_cmd(KIND_TEXT, 8'hA5);            // text against empty pattern
        push_cmd(KIND_RESTART, rand_sym());
        push_cmd(KIND_TEXT, 8'h00);
        push_cmd(KIND_APPEND, 8'h61);          // pattern "aba"
        push_cmd(KIND_APPEND, 8'h62);
        push_cmd(KIND_APPEND, 8'h61);
        push_cmd(KIND_TEXT, 8'h61);            // "ababa": two overlapping hits
        push_cmd(KIND_TEXT, 8'h62);
        push_cmd(KIND_TEXT, 8'h61);
        push_cmd(KIND_TEXT, 8'h62);
        push_cmd(KIND_TEXT, 8'h61);
        push_cmd(KIND_APPEND, 8'h62);          // grow pattern mid-scan
        push_cmd(KIND_TEXT, 8'h62);
        push_cmd(KIND_RESTART, rand_sym());
        push_cmd(KIND_TEXT, 8'h61);
        push_cmd(KIND_CLEAR, 8'hFF);
        push_cmd(KIND_TEXT, 8'h61);            // empty again after clear
        push_cmd(KIND_APPEND, 8'hFF);          // symbol extremes
        push_cmd(KIND_APPEND, 8'h00);
        push_cmd(KIND_TEXT, 8'hFF);
        push_cmd(KIND_TEXT, 8'h00);
        push_cmd(KIND_TEXT, 8'hFF);
        push_cmd(KIND_TEXT, 8'h00);
        push_cmd(KIND_CLEAR, 8'h00);
    endtask

    // load a short pattern (mostly after a clear) and scan text with planted copies
    task automatic scan_scenario();
        sym_t base;
        int   alpha;
        int   plen;
        int   tlen;
        int   roll;
        sym_t pat[$];
        base  = rand_sym();
        alpha = $urandom_range(1, 3);
        roll  = $urandom_range(0, 99);
        if (roll < 80)
            plen = $urandom_range(1, 6);
        else if (roll < 95)
            plen = $urandom_range(7, 20);
        else
            plen = $urandom_range(40, 64);
        // a restart instead of a clear lets the pattern keep growing toward full
        if ($urandom_range(0, 4) != 0)
            push_cmd(KIND_CLEAR, rand_sym());
        else
            push_cmd(KIND_RESTART, rand_sym());
        for (int i = 0; i < plen; i++)
        begin
            pat.push_back(alpha_sym(base, alpha));
            push_cmd(KIND_APPEND, pat[i]);
        end
        tlen = $urandom_range(8, 40);
        for (int i = 0; i < tlen; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
                foreach (pat[j])
                    push_cmd(KIND_TEXT, pat[j]);
            else if (roll < 18)
                push_cmd(KIND_RESTART, rand_sym());
            else if (roll < 20)
                push_cmd(KIND_APPEND, alpha_sym(base, alpha));
            else
                push_cmd(KIND_TEXT, alpha_sym(base, alpha));
        end
    endtask

    // fill the store, push past it, then scan; a uniform pattern gives the
    // longest fallback chain when the run of equal bytes is broken
    task automatic full_store_scenario();
        sym_t a;
        sym_t b;
        bit   uniform;
        int   run;
        sym_t pat[$];
        a       = rand_sym();
        b       = a ^ sym_t'(1 << $urandom_range(0, 7));
        uniform = 1'($urandom_range(0, 1));
        push_cmd(KIND_CLEAR, rand_sym());
        for (int i = 0; i < PAT_DEPTH; i++)
        begin
            pat.push_back((uniform || $urandom_range(0, 1) == 0) ? a : b);
            push_cmd(KIND_APPEND, pat[i]);
        end
        repeat ($urandom_range(1, 3))
            push_cmd(KIND_APPEND, rand_sym());
        if (uniform)
        begin
            run = $urandom_range(60, 80);
            repeat (run)
                push_cmd(KIND_TEXT, a);
            push_cmd(KIND_TEXT, b);
            repeat (run)
                push_cmd(KIND_TEXT, a);
        end
        else
        begin
            repeat ($urandom_range(5, 20))
                push_cmd(KIND_TEXT, ($urandom_range(0, 1) == 0) ? a : b);
            foreach (pat[j])
                push_cmd(KIND_TEXT, pat[j]);
            repeat ($urandom_range(5, 20))
                push_cmd(KIND_TEXT, ($urandom_range(0, 1) == 0) ? a : b);
        end
    endtask

    // gap lengths: mostly none or short, a few long, with calm stretches
    function automatic int next_gap(inout int calm_left);
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm_left = $urandom_range(20, 60);
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: command beats change on the falling edge; valid stays up
    // across back-to-back beats.
    // ------------------------------------------------------------------
    logic item_taken;     // a command beat was accepted at the last rising edge
    logic result_taken;   // a result beat was accepted at the last rising edge
    int   send_gap;
    int   send_calm;
    int   hold_left;
    int   recv_calm;

    always @(negedge clk)
    begin
        scan_cmd_t cmd;
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!(item_ch.valid && !item_taken))
        begin
            if (item_taken)
                send_gap = next_gap(send_calm);
            if (send_gap > 0 || command_queue.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                item_ch.valid <= 1'b0;
            end
            else
            begin
                cmd = command_queue.pop_front();
                item_ch.valid  <= 1'b1;
                item_ch.kind   <= cmd.kind;
                item_ch.symbol <= cmd.symbol;
            end
        end
    end

    // result side back-pressure, also at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (hold_left == 0 && (result_taken || $urandom_range(0, 3) == 0))
                hold_left = next_gap(recv_calm);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge, predict on each
    // command beat, check each result beat against the oldest prediction.
    // ------------------------------------------------------------------
    int mismatches;
    int beats_in;
    int quiet_cycles;
    int n_append, n_dropped, n_text, n_hits, n_clear, n_restart, deepest;

    function automatic void report_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        kms_result_t got;
        kms_result_t want;
        if (!rst_n)
        begin
            item_taken   <= 1'b0;
            result_taken <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            item_taken   <= item_ch.valid && item_ch.ready;
            result_taken <= result_ch.valid && result_ch.ready;
            quiet_cycles <= ((item_ch.valid && item_ch.ready) ||
                             (result_ch.valid && result_ch.ready)) ? 0 : quiet_cycles + 1;

            // results first: one landing now belongs to an earlier command
            if (result_ch.valid && result_ch.ready)
            begin
                got.match_found    = result_ch.match_found;
                got.match_total    = result_ch.match_total;
                got.matched_prefix = result_ch.matched_prefix;
                got.pattern_size   = result_ch.pattern_size;
                got.overflow       = result_ch.overflow;
                if (predicted_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with none expected: found=%0d total=%0d",
                             $time, got.match_found, got.match_total);
                    $display("    prefix=%0d size=%0d ovf=%0d",
                             got.matched_prefix, got.pattern_size, got.overflow);
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    report_field("match_found",
                                 32'(want.match_found), 32'(got.match_found));
                    report_field("match_total",
                                 32'(want.match_total), 32'(got.match_total));
                    report_field("matched_prefix",
                                 32'(want.matched_prefix), 32'(got.matched_prefix));
                    report_field("pattern_size",
                                 32'(want.pattern_size), 32'(got.pattern_size));
                    report_field("overflow",
                                 32'(want.overflow), 32'(got.overflow));
                end
            end

            if (item_ch.valid && item_ch.ready)
            begin
                want = kmp_step(item_ch.kind, item_ch.symbol);
                predicted_reports.push_back(want);
                beats_in++;
                case (item_ch.kind)
                    KIND_APPEND:  n_append++;
                    KIND_TEXT:    n_text++;
                    KIND_CLEAR:   n_clear++;
                    default:      n_restart++;
                endcase
                if (want.overflow)
                    n_dropped++;
                if (want.match_found)
                    n_hits++;
                if (int'(want.matched_prefix) > deepest)
                    deepest = int'(want.matched_prefix);
            end
        end
    end

    // no beat on either channel for too long means the dut hung
    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: timeout, %0d results still expected", $time, predicted_reports.size());
        $display("tb_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int total_cmds;
        int roll;
        rst_n            = 1'b0;
        item_ch.valid    = 1'b0;
        item_ch.kind     = KIND_APPEND;
        item_ch.symbol   = '0;
        result_ch.ready  = 1'b0;
        item_taken       = 1'b0;
        result_taken     = 1'b0;
        send_gap         = 0;
        send_calm        = 0;
        hold_left        = 0;
        recv_calm        = 0;
        mismatches       = 0;
        beats_in         = 0;
        quiet_cycles     = 0;
        n_append = 0; n_dropped = 0; n_text = 0; n_hits = 0;
        n_clear = 0; n_restart = 0; deepest = 0;
        pat_len          = '0;
        build_border     = '0;
        cur_prefix       = '0;
        hit_count        = '0;

        directed_cmds();
        total_cmds = command_queue.size() + RANDOM_CMDS;
        while (command_queue.size() < total_cmds)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 76)
                scan_scenario();
            else if (roll < 80)
                full_store_scenario();
            else
                repeat ($urandom_range(1, 6))
                    push_cmd(kind_t'($urandom_range(0, 3)), rand_sym());
        end
        total_cmds = command_queue.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every command sent and every result back, then watch for stray beats
        while (beats_in < total_cmds || predicted_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Ran %0d commands: %0d appends (%0d dropped on a full store),",
                 beats_in, n_append, n_dropped);
        $display("%0d clears, %0d restarts", n_clear, n_restart);
        $display("Scanned %0d text bytes, %0d occurrences, deepest matched prefix %0d,",
                 n_text, n_hits, deepest);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
